@@ rtl/core/rotated_sorted_array_search_defines.svh @@
// Assertion macros shared by the rotated sorted array search RTL.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define RSAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RSAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/rsas_pkg.sv @@
// Shared types and constants of the rotated sorted array search block.
package rsas_pkg;

  localparam int unsigned ElemW        = 32;
  localparam int unsigned LoadIdxW     = 10;
  localparam int unsigned CountW       = 11;
  localparam int unsigned DepthDefault = 1024;
  localparam logic [CountW-1:0] CountReset = 11'd1024;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef struct packed {
    op_e                       operation;
    logic [LoadIdxW-1:0]       load_index;
    logic signed [ElemW-1:0]   element_value;
    logic signed [ElemW-1:0]   search_key;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [LoadIdxW-1:0] found_index;
  } rsp_t;

  typedef struct packed {
    logic [CountW-1:0] element_count;
  } cfg_t;

endpackage

@@ rtl/core/rsas_stream_if.sv @@
// Valid/ready channel carrying one payload per transfer.
interface rsas_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rotated_sorted_array_search.sv @@
// Rotated sorted array search: element store, pivot search and binary search sequencer.
// Load: writes the element and gives no result; the next item is taken on the next cycle.
// Search: reads the first and last elements, runs the pivot search and then the binary search,
// and hands the result to the output register; a count of zero goes straight to the output.
// No new item is taken until the result is handed over, which waits on any output stall.
// Reset clears sequencer and output valid, sets element_count to 1024; contents stay undefined.
module rotated_sorted_array_search
  import rsas_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsas_stream_if.sink   cfg_i,
  rsas_stream_if.sink   in_i,
  rsas_stream_if.source out_o
);

  `include "rotated_sorted_array_search_defines.svh"

  // Address width, position width (signed, room for -1 and DEPTH) and count compare width.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = AW + 2;
  localparam int unsigned CW = ((AW + 1) > CountW) ? (AW + 1) : CountW;

  typedef logic signed [PW-1:0] pos_t;

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001, // take loads and searches
    S_PLO   = 9'b000000010, // read the first element
    S_PHI   = 9'b000000100, // capture first, read the last element
    S_PLAST = 9'b000001000, // capture last element
    S_PCMP  = 9'b000010000, // pivot search: test range, issue mid read
    S_PUPD  = 9'b000100000, // pivot search: narrow range on mid value
    S_BCMP  = 9'b001000000, // binary search: test bounds, issue mid read
    S_BUPD  = 9'b010000000, // binary search: compare mid value with key
    S_FIN   = 9'b100000000  // hand result to the output register
  } state_e;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       count_q;
  logic signed [ElemW-1:0] mem_q [DEPTH];
  logic signed [ElemW-1:0] rdata_q;
  logic signed [ElemW-1:0] key_q, key_d;
  logic signed [ElemW-1:0] vlo_q, vlo_d;
  logic signed [ElemW-1:0] vhi_q, vhi_d;
  logic signed [ElemW-1:0] vlast_q, vlast_d;
  pos_t                    lo_q, lo_d;
  pos_t                    hi_q, hi_d;
  pos_t                    mid_q, mid_d;
  pos_t                    last_q, last_d;
  logic                    res_found_q, res_found_d;
  pos_t                    res_idx_q, res_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q;
  logic [LoadIdxW-1:0]     out_idx_q;

  logic          in_fire;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          out_load;
  logic [CW-1:0] n_clip;
  pos_t          last_c;
  pos_t          diff_c;
  pos_t          mid_c;

  // Channel handshakes: configuration is always taken, items only while idle.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid            = out_valid_q;
  assign out_o.data.found       = out_found_q;
  assign out_o.data.found_index = out_idx_q;

  // Count in use saturates at the store depth.
  assign n_clip = (CW'(count_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(count_q);
  assign last_c = pos_t'(n_clip - CW'(1));

  // Shared midpoint unit; the range is never negative where the midpoint is kept.
  assign diff_c = hi_q - lo_q;
  assign mid_c  = lo_q + (diff_c >>> 1);

  // Drop loads beyond the store depth.
  assign mem_we = in_fire && (in_i.data.operation == OP_LOAD) &&
                  (32'(in_i.data.load_index) < DEPTH);
  assign waddr  = AW'(in_i.data.load_index);

  // Read address per state; data returns registered in the following cycle.
  always_comb begin
    case (state_q)
      S_PHI:          raddr = last_q[AW-1:0];
      S_PCMP, S_BCMP: raddr = mid_c[AW-1:0];
      default:        raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= in_i.data.element_value;
    end
    rdata_q <= mem_q[raddr];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    vlo_d       = vlo_q;
    vhi_d       = vhi_q;
    vlast_d     = vlast_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    last_d      = last_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.data.operation == OP_SEARCH)) begin
          key_d = in_i.data.search_key;
          if (n_clip == '0) begin
            res_found_d = 1'b0;
            res_idx_d   = '0;
            state_d     = S_FIN;
          end else begin
            lo_d    = '0;
            hi_d    = last_c;
            last_d  = last_c;
            state_d = S_PLO;
          end
        end
      end
      S_PLO: begin
        state_d = S_PHI;
      end
      S_PHI: begin
        vlo_d   = rdata_q;
        state_d = S_PLAST;
      end
      S_PLAST: begin
        vhi_d   = rdata_q;
        vlast_d = rdata_q;
        state_d = S_PCMP;
      end
      S_PCMP: begin
        if (vlo_q > vhi_q) begin
          if (mid_c == lo_q) begin
            // Pivot found: pick the half that can hold the key.
            if (key_q == vlast_q) begin
              res_found_d = 1'b1;
              res_idx_d   = last_q;
              state_d     = S_FIN;
            end else if (key_q > vlast_q) begin
              lo_d    = '0;
              hi_d    = mid_c;
              state_d = S_BCMP;
            end else begin
              lo_d    = mid_c + pos_t'(1);
              hi_d    = last_q;
              state_d = S_BCMP;
            end
          end else begin
            mid_d   = mid_c;
            state_d = S_PUPD;
          end
        end else begin
          // Not rotated: search the whole range.
          lo_d    = '0;
          hi_d    = last_q;
          state_d = S_BCMP;
        end
      end
      S_PUPD: begin
        if (rdata_q < vlo_q) begin
          hi_d  = mid_q;
          vhi_d = rdata_q;
        end else begin
          lo_d  = mid_q;
          vlo_d = rdata_q;
        end
        state_d = S_PCMP;
      end
      S_BCMP: begin
        if (lo_q <= hi_q) begin
          mid_d   = mid_c;
          state_d = S_BUPD;
        end else begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = S_FIN;
        end
      end
      S_BUPD: begin
        if (rdata_q == key_q) begin
          res_found_d = 1'b1;
          res_idx_d   = mid_q;
          state_d     = S_FIN;
        end else begin
          if (rdata_q > key_q) begin
            hi_d = mid_q - pos_t'(1);
          end else begin
            lo_d = mid_q + pos_t'(1);
          end
          state_d = S_BCMP;
        end
      end
      S_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CountReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        count_q <= cfg_i.data.element_count;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    vlo_q       <= vlo_d;
    vhi_q       <= vhi_d;
    vlast_q     <= vlast_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    last_q      <= last_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_idx_q   <= LoadIdxW'(res_idx_q);
    end
  end

  `RSAS_ASSERT(a_search_leaves_idle,
    (in_fire && (in_i.data.operation == OP_SEARCH)) |=> (state_q != S_IDLE),
    "search transfer did not start the sequencer")
  `RSAS_ASSERT(a_pivot_range_ordered,
    (state_q == S_PCMP) |-> (lo_q <= hi_q),
    "pivot search range inverted")
  `RSAS_ASSERT(a_probe_in_bounds,
    (state_q == S_BUPD) |-> ((mid_q >= lo_q) && (mid_q <= hi_q)),
    "binary search probe outside bounds")
  `RSAS_ASSERT(a_miss_index_zero,
    (out_o.valid && !out_o.data.found) |-> (out_o.data.found_index == '0),
    "miss result carries a nonzero index")
  `RSAS_ASSERT_ALWAYS(a_reset_no_result,
    !rst_ni |-> !out_o.valid,
    "result offered during reset")

endmodule
